@@ sv/gof_pkg.sv @@
// Package for the glyph outline filter: row and register widths, job record
// passed from front to back, and the outline and width-mask functions.
// No dependencies.
package gof_pkg;

   localparam int ROW_WIDTH = 64;
   localparam int CFG_WIDTH = 7;
   localparam int MAX_WIDTH = 64;
   localparam logic [CFG_WIDTH-1:0] WIDTH_RESET = 7'h40;

   typedef logic [ROW_WIDTH-1:0] row_type;
   typedef logic [CFG_WIDTH-1:0] width_type;

   typedef enum logic [1:0] {
      JOB_SINGLE = 2'd0,
      JOB_MIDDLE = 2'd1,
      JOB_DOUBLE = 2'd2
   } job_kind_type;

   typedef struct packed {
      row_type      row_above;
      row_type      row_center;
      row_type      row_down;
      job_kind_type kind;
   } job_type;

   function automatic row_type valid_mask(input width_type w);
      width_type ws;
      row_type   m;
      ws = (w > width_type'(MAX_WIDTH)) ? width_type'(MAX_WIDTH) : w;
      for (int i = 0; i < ROW_WIDTH; i++) begin
         m[i] = (width_type'(ROW_WIDTH - 1 - i) < ws);
      end
      return m;
   endfunction

   function automatic row_type outline_row(input row_type up, input row_type mid,
                                           input row_type down, input row_type m);
      row_type a;
      row_type c;
      row_type b;
      a = up & m;
      c = mid & m;
      b = down & m;
      return (a | b | (c >> 1) | (c << 1)) & ~c & m;
   endfunction

endpackage

@@ sv/gof_front.sv @@
// Front end: takes input rows, holds the two previous rows and makes an
// outline job of each row but a non-last first row. Depends on gof_pkg.
module gof_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  gof_pkg::row_type req_tdata,   // [63:0] row_bits
   input  logic             req_tlast,   // last_row
   input  logic             job_full,
   output logic             job_push,
   output gof_pkg::job_type job_data
);
   import gof_pkg::*;

   row_type    row_above_ff, row_above_in;
   row_type    row_center_ff, row_center_in;
   logic [1:0] rows_seen_ff, rows_seen_in;
   logic       accept;
   logic       busy;

   assign req_tready = !job_full;
   assign accept     = req_tvalid && req_tready;
   assign busy       = (rows_seen_ff != 2'd0);
   assign job_push   = accept && (busy || req_tlast);

   always_comb begin
      job_data.row_above  = row_above_ff;
      job_data.row_center = row_center_ff;
      job_data.row_down   = req_tdata;
      if (!busy) begin
         job_data.kind = JOB_SINGLE;
      end else if (req_tlast) begin
         job_data.kind = JOB_DOUBLE;
      end else begin
         job_data.kind = JOB_MIDDLE;
      end

      row_above_in  = row_above_ff;
      row_center_in = row_center_ff;
      rows_seen_in  = rows_seen_ff;
      if (accept) begin
         if (req_tlast) begin
            row_above_in  = '0;
            row_center_in = '0;
            rows_seen_in  = 2'd0;
         end else begin
            row_above_in  = busy ? row_center_ff : '0;
            row_center_in = req_tdata;
            rows_seen_in  = busy ? 2'd2 : 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_above_ff  <= '0;
         row_center_ff <= '0;
         rows_seen_ff  <= 2'd0;
      end else begin
         row_above_ff  <= row_above_in;
         row_center_ff <= row_center_in;
         rows_seen_ff  <= rows_seen_in;
      end
   end

endmodule

@@ sv/gof_queue.sv @@
// Two-entry job queue between front and back ends.
// Depends on gof_pkg.
module gof_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  gof_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output gof_pkg::job_type head_data
);
   import gof_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ sv/gof_back.sv @@
// Back end: computes outlines from queued jobs and drives the result
// register. A double job gives two results. Depends on gof_pkg.
module gof_back (
   input  logic               clock,
   input  logic               reset,
   input  gof_pkg::width_type glyph_width,
   input  logic               head_valid,
   input  gof_pkg::job_type   head_data,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output gof_pkg::row_type   rsp_tdata,   // [63:0] outline_bits
   output logic               rsp_tlast    // final_out
);
   import gof_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   row_type rsp_data_ff;
   logic    rsp_last_ff;
   logic    phase_ff, phase_in;
   logic    load;
   row_type sel_up, sel_mid, sel_down;
   logic    sel_last;
   logic    second;

   assign load   = head_valid && (!rsp_valid_ff || rsp_tready);
   assign second = phase_ff;

   always_comb begin
      sel_up   = '0;
      sel_mid  = head_data.row_down;
      sel_down = '0;
      sel_last = 1'b1;
      pop      = 1'b0;
      phase_in = phase_ff;
      unique case (head_data.kind)
         JOB_SINGLE: begin
            pop = load;
         end
         JOB_MIDDLE: begin
            sel_up   = head_data.row_above;
            sel_mid  = head_data.row_center;
            sel_down = head_data.row_down;
            sel_last = 1'b0;
            pop      = load;
         end
         JOB_DOUBLE: begin
            if (second) begin
               sel_up  = head_data.row_center;
               sel_mid = head_data.row_down;
            end else begin
               sel_up   = head_data.row_above;
               sel_mid  = head_data.row_center;
               sel_down = head_data.row_down;
               sel_last = 1'b0;
            end
            pop = load && second;
            if (load) begin
               phase_in = !second;
            end
         end
         default: begin
            pop = load;
         end
      endcase
      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= outline_row(sel_up, sel_mid, sel_down, valid_mask(glyph_width));
         rsp_last_ff <= sel_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ sv/glyph_outline_filter.sv @@
// Glyph outline filter: 4-neighbor outer boundary of a 1-bit glyph, one row per transfer.
// Throughput one row per cycle while the job queue is not full; a last row after held
// rows gives one extra result. Results pass a queue entry and then the output register.
// Reset clears held rows, queue and output valid; glyph_width resets to 64.
// Depends on gof_pkg, gof_front, gof_queue, gof_back.
module glyph_outline_filter (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  gof_pkg::row_type   req_tdata,   // [63:0] row_bits
   input  logic               req_tlast,   // last_row
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output gof_pkg::row_type   rsp_tdata,   // [63:0] outline_bits
   output logic               rsp_tlast,   // final_out
   input  logic               csr_valid,
   output logic               csr_ready,
   input  gof_pkg::width_type csr_data     // [6:0] glyph_width
);
   import gof_pkg::*;

   width_type glyph_width_ff;
   logic      job_full;
   logic      job_push;
   job_type   job_data;
   logic      head_valid;
   job_type   head_data;
   logic      pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_width_ff <= WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         glyph_width_ff <= csr_data;
      end
   end

   gof_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .job_full   (job_full),
      .job_push   (job_push),
      .job_data   (job_data)
   );

   gof_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_data  (job_data),
      .full       (job_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   gof_back u_back (
      .clock       (clock),
      .reset       (reset),
      .glyph_width (glyph_width_ff),
      .head_valid  (head_valid),
      .head_data   (head_data),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

@@ test/glyph_outline_filter_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for glyph_outline_filter: streams glyph rows in, predicts every
// row's 4-neighbor outline and checks the result stream in order. Needs gof_pkg and the RTL.
module glyph_outline_filter_test;
   import gof_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 6;
   localparam int RANDOM_ROWS   = 1600;

   typedef struct {
      row_type bits;
      logic    last;
   } glyph_row;

   typedef struct {
      row_type bits;
      logic    fin;
   } outline_rec;

   logic      clock      = 1'b0;
   logic      reset      = 1'b1;
   logic      req_tvalid = 1'b0;
   logic      req_tready;
   row_type   req_tdata  = '0;
   logic      req_tlast  = 1'b0;
   logic      rsp_tvalid;
   logic      rsp_tready = 1'b0;
   row_type   rsp_tdata;
   logic      rsp_tlast;
   logic      csr_valid  = 1'b0;
   logic      csr_ready;
   width_type csr_data   = WIDTH_RESET;

   glyph_row   row_pending[$];
   outline_rec outline_due[$];

   width_type  width_now   = WIDTH_RESET;
   row_type    held_above  = '0;
   row_type    held_center = '0;
   logic [1:0] held_count  = 2'd0;

   int  req_issued   = 0;
   int  req_accepted = 0;
   int  rsp_accepted = 0;
   int  csr_writes   = 0;
   int  error_count  = 0;
   int  rows_queued  = 0;
   int  send_wait    = 0;
   int  recv_wait    = 0;
   int  recv_seen    = 0;
   bit  send_burst   = 1'b0;
   bit  recv_burst   = 1'b0;
   bit  drain_hold   = 1'b0;

   always #1 clock = ~clock;

   glyph_outline_filter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   function automatic row_type width_mask(input width_type w);
      int n;
      n = (w > width_type'(MAX_WIDTH)) ? MAX_WIDTH : int'(w);
      if (n == 0) return '0;
      return ~row_type'(0) << (ROW_WIDTH - n);
   endfunction

   function automatic row_type trace_outline(input row_type up, input row_type mid,
                                             input row_type down);
      row_type m;
      row_type u;
      row_type c;
      row_type d;
      m = width_mask(width_now);
      u = up & m;
      c = mid & m;
      d = down & m;
      return (u | d | {1'b0, c[ROW_WIDTH-1:1]} | {c[ROW_WIDTH-2:0], 1'b0}) & ~c & m;
   endfunction

   task automatic predict_outline(input row_type row, input logic last);
      if (held_count == 2'd0) begin
         if (last) begin
            outline_due.push_back('{trace_outline('0, row, '0), 1'b1});
         end else begin
            held_above  = '0;
            held_center = row;
            held_count  = 2'd1;
         end
      end else begin
         outline_due.push_back('{trace_outline(held_above, held_center, row), 1'b0});
         if (last) begin
            outline_due.push_back('{trace_outline(held_center, row, '0), 1'b1});
            held_above  = '0;
            held_center = '0;
            held_count  = 2'd0;
         end else begin
            held_above  = held_center;
            held_center = row;
            held_count  = 2'd2;
         end
      end
   endtask

   function automatic int pick_gap(input bit burst);
      return burst ? 0 : $urandom_range(0, 19);
   endfunction

   function automatic row_type random_row();
      row_type r;
      case ($urandom_range(0, 7))
         0: r = '0;
         1: r = '1;
         4, 5: r = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
         6: r = {$urandom, $urandom} | {$urandom, $urandom};
         7: r = row_type'(1) << $urandom_range(0, ROW_WIDTH - 1);
         default: r = {$urandom, $urandom};
      endcase
      return r;
   endfunction

   function automatic int pick_width();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return MAX_WIDTH;
         2: return 1;
         3: return $urandom_range(MAX_WIDTH + 1, 127);
         4: return 127;
         default: return $urandom_range(1, MAX_WIDTH);
      endcase
   endfunction

   task automatic push_row(input row_type bits, input logic last);
      row_pending.push_back('{bits, last});
      rows_queued++;
   endtask

   // sender state settles at negedge, expectations at posedge; sample each off its edge
   task automatic wait_for_idle();
      bit sender_quiet;
      do begin
         @(posedge clock);
         sender_quiet = (row_pending.size() == 0) && !req_tvalid;
         @(negedge clock);
      end while (!sender_quiet || outline_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_width(input int w);
      int seen;
      seen = csr_writes;
      csr_data  <= width_type'(w);
      csr_valid <= 1'b1;
      do @(negedge clock); while (csr_writes == seen);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin : monitor
      outline_rec want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            width_now = csr_data;
            csr_writes++;
         end
         if (req_tvalid && req_tready) begin
            predict_outline(req_tdata, req_tlast);
            req_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_accepted++;
            if (outline_due.size() == 0) begin
               error_count++;
               $display("%0t: unexpected transfer, expected none, got %h last %b",
                        $time, rsp_tdata, rsp_tlast);
            end else begin
               want = outline_due.pop_front();
               if (rsp_tdata !== want.bits) begin
                  error_count++;
                  $display("%0t: outline_bits expected %h, got %h",
                           $time, want.bits, rsp_tdata);
               end
               if (rsp_tlast !== want.fin) begin
                  error_count++;
                  $display("%0t: final_out expected %b, got %b",
                           $time, want.fin, rsp_tlast);
               end
            end
         end
      end
   end

   always @(negedge clock) begin : driver
      logic     sending;
      glyph_row item;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         sending = req_tvalid;
         if (req_tvalid && req_accepted == req_issued) begin
            sending = 1'b0;
            if ($urandom_range(0, 39) == 0) send_burst = ~send_burst;
            if ($urandom_range(0, 99) == 0) drain_hold = 1'b1;
            send_wait = pick_gap(send_burst);
         end
         if (!sending) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (row_pending.size() > 0 &&
                         !(drain_hold && outline_due.size() != 0)) begin
               drain_hold = 1'b0;
               item = row_pending.pop_front();
               req_tdata <= item.bits;
               req_tlast <= item.last;
               req_issued++;
               sending = 1'b1;
            end
         end
         req_tvalid <= sending;

         if (rsp_accepted != recv_seen) begin
            recv_seen = rsp_accepted;
            if ($urandom_range(0, 39) == 0) recv_burst = ~recv_burst;
            recv_wait = pick_gap(recv_burst);
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int phase_len;
      int count;
      int glen;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset width: empty, full, corner pixels, isolated blob, dense pair
      push_row('0, 1'b1);
      push_row('1, 1'b1);
      push_row(64'h8000_0000_0000_0001, 1'b1);
      push_row('0, 1'b0);
      push_row(64'h0000_0001_8000_0000, 1'b0);
      push_row('0, 1'b1);
      push_row('1, 1'b0);
      push_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
      wait_for_idle();

      // bits past the width must not act as neighbors
      write_width(8);
      push_row('1, 1'b1);
      push_row(64'h0100_0000_0000_0000, 1'b0);
      push_row(64'h00FF_FFFF_FFFF_FFFF, 1'b1);
      wait_for_idle();

      write_width(0);
      push_row(64'h0F0F_0000_F0F0_1234, 1'b0);
      push_row(64'h0000_0000_0000_0000, 1'b1);
      wait_for_idle();

      write_width(127);
      push_row(64'h0000_0000_0000_0001, 1'b0);
      push_row(64'h8000_0000_0000_0000, 1'b0);
      push_row(64'h0000_0000_0000_0000, 1'b1);
      wait_for_idle();

      write_width(1);
      push_row(64'h8000_0000_0000_0000, 1'b0);
      push_row(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
      wait_for_idle();

      // width change while a row is held
      write_width(64);
      push_row(64'hF800_0000_0000_0000, 1'b0);
      wait_for_idle();
      write_width(5);
      push_row(64'h2000_0000_0000_0000, 1'b0);
      push_row(64'hFFFF_0000_0000_0000, 1'b1);
      wait_for_idle();

      write_width(65);
      push_row(64'h0000_0000_0000_0002, 1'b0);
      push_row(64'h5555_5555_5555_5555, 1'b1);

      while (rows_queued < RANDOM_ROWS) begin
         wait_for_idle();
         write_width(pick_width());
         phase_len = $urandom_range(40, 160);
         count = 0;
         while (count < phase_len) begin
            glen = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 12);
            for (int i = 0; i < glen; i++) push_row(random_row(), i == glen - 1);
            count += glen;
         end
         // leave a glyph open across the next width write
         if ($urandom_range(0, 2) == 0) push_row(random_row(), 1'b0);
      end
      push_row(random_row(), 1'b1);
      wait_for_idle();

      if (error_count == 0) begin
         $display("glyph_outline_filter test passed");
      end else begin
         $display("glyph_outline_filter test failed");
      end
      $finish;
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("glyph_outline_filter test failed");
      $finish;
   end

endmodule

@@ glyph_outline_filter.f @@
sv/gof_pkg.sv
sv/gof_front.sv
sv/gof_queue.sv
sv/gof_back.sv
sv/glyph_outline_filter.sv
test/glyph_outline_filter_test.sv
